[hw/rtl/rlri_pkg.sv]
// Shared constants and types of the run-length region intersection block.
`default_nettype none

package rlri_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int COORD_BITS_DEF  = 16;

   // Request opcodes; OPC_NONE is the unused code and is discarded on entry.
   typedef enum logic [1:0] {
      OPC_FIRST  = 2'd0,
      OPC_SECOND = 2'd1,
      OPC_END    = 2'd2,
      OPC_NONE   = 2'd3
   } opcode_type;

endpackage

`default_nettype wire

[hw/rtl/run_length_region_intersection_core.sv]
// Run-length region intersection: two regions in, intersection runs out.
//
// Requests carry an opcode and one run (row, start, exclusive end). Opcode
// first or second queues the run for that region; opcode end empties both
// queues, clears the overflow flag and returns one result with frame_done
// set. The unused opcode is discarded with no result. Each region keeps a
// queue of QUEUE_DEPTH runs; a run sent to a full queue is dropped and sets
// the sticky overflow flag reported on every result.
// A two-entry command buffer separates request acceptance from the merge
// engine. The engine takes a request in its idle state; each head
// comparison that it triggers passes a queue RAM read state and a compare
// state, and a flush state releases the last result. Each result is held
// until the next overlap or the end of the merge so that is_last can be
// marked. An end request is answered from the idle state once the result
// register is free. Reset clears both queues, the flag and all valid state.
// When the receiver stalls the result register holds, the engine stops at
// its next result, and req_ready drops once the command buffer fills.
`default_nettype none

module run_length_region_intersection_core #(
   parameter int QUEUE_DEPTH = rlri_pkg::QUEUE_DEPTH_DEF,
   parameter int COORD_BITS  = rlri_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [COORD_BITS-1:0] req_run_row,
   input  wire logic [COORD_BITS-1:0] req_run_start,
   input  wire logic [COORD_BITS-1:0] req_run_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_out_row,
   output logic [COORD_BITS-1:0]      rsp_out_start,
   output logic [COORD_BITS-1:0]      rsp_out_end,
   output logic                       rsp_is_last,
   output logic                       rsp_frame_done,
   output logic                       rsp_overflow
);

   logic                  cmd_valid;
   logic                  cmd_ready;
   rlri_pkg::opcode_type  cmd_kind;
   logic [COORD_BITS-1:0] cmd_row;
   logic [COORD_BITS-1:0] cmd_start;
   logic [COORD_BITS-1:0] cmd_end;

   rlri_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_run_row   (req_run_row),
      .req_run_start (req_run_start),
      .req_run_end   (req_run_end),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd_kind      (cmd_kind),
      .cmd_row       (cmd_row),
      .cmd_start     (cmd_start),
      .cmd_end       (cmd_end)
   );

   rlri_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .COORD_BITS(COORD_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_kind       (cmd_kind),
      .cmd_row        (cmd_row),
      .cmd_start      (cmd_start),
      .cmd_end        (cmd_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_start  (rsp_out_start),
      .rsp_out_end    (rsp_out_end),
      .rsp_is_last    (rsp_is_last),
      .rsp_frame_done (rsp_frame_done),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

`default_nettype wire

[hw/rtl/rlri_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rlri_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/rlri_front.sv]
// Front end: accepts requests, discards unused opcodes, buffers commands.
`default_nettype none

module rlri_front #(
   parameter int COORD_BITS = rlri_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [COORD_BITS-1:0] req_run_row,
   input  wire logic [COORD_BITS-1:0] req_run_start,
   input  wire logic [COORD_BITS-1:0] req_run_end,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output rlri_pkg::opcode_type       cmd_kind,
   output logic [COORD_BITS-1:0]      cmd_row,
   output logic [COORD_BITS-1:0]      cmd_start,
   output logic [COORD_BITS-1:0]      cmd_end
);

   localparam int FifoDepth = 2;

   rlri_pkg::opcode_type      kind_ff  [FifoDepth];
   logic [COORD_BITS-1:0]     row_ff   [FifoDepth];
   logic [COORD_BITS-1:0]     start_ff [FifoDepth];
   logic [COORD_BITS-1:0]     end_ff   [FifoDepth];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                fill_ff, fill_in;
   logic                      push, pop;
   rlri_pkg::opcode_type      req_kind;

   assign req_kind  = rlri_pkg::opcode_type'(req_opcode);
   assign req_ready = (fill_ff != 2'(FifoDepth));
   assign push      = req_valid && req_ready && (req_kind != rlri_pkg::OPC_NONE);
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;

   assign cmd_kind  = kind_ff[rd_ptr_ff];
   assign cmd_row   = row_ff[rd_ptr_ff];
   assign cmd_start = start_ff[rd_ptr_ff];
   assign cmd_end   = end_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         kind_ff[wr_ptr_ff]  <= req_kind;
         row_ff[wr_ptr_ff]   <= req_run_row;
         start_ff[wr_ptr_ff] <= req_run_start;
         end_ff[wr_ptr_ff]   <= req_run_end;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rlri_back.sv]
// Back end: per-region run queues, merge sequencer and result register.
`default_nettype none

module rlri_back #(
   parameter int QUEUE_DEPTH = rlri_pkg::QUEUE_DEPTH_DEF,
   parameter int COORD_BITS  = rlri_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  rlri_pkg::opcode_type       cmd_kind,
   input  wire logic [COORD_BITS-1:0] cmd_row,
   input  wire logic [COORD_BITS-1:0] cmd_start,
   input  wire logic [COORD_BITS-1:0] cmd_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_out_row,
   output logic [COORD_BITS-1:0]      rsp_out_start,
   output logic [COORD_BITS-1:0]      rsp_out_end,
   output logic                       rsp_is_last,
   output logic                       rsp_frame_done,
   output logic                       rsp_overflow
);

   localparam int AddrBits  = $clog2(QUEUE_DEPTH);
   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
   localparam int SumBits   = AddrBits + 1;
   localparam int RunBits   = 3 * COORD_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FLUSH
   } state_type;

   state_type              state_ff, state_in;
   logic [AddrBits-1:0]    head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic [CountBits-1:0]   cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic                   ovf_ff, ovf_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [COORD_BITS-1:0]  pend_row_ff, pend_row_in;
   logic [COORD_BITS-1:0]  pend_start_ff, pend_start_in;
   logic [COORD_BITS-1:0]  pend_end_ff, pend_end_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]  rsp_row_ff, rsp_row_in;
   logic [COORD_BITS-1:0]  rsp_start_ff, rsp_start_in;
   logic [COORD_BITS-1:0]  rsp_end_ff, rsp_end_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   wr_a, wr_b;
   logic [AddrBits-1:0]    tail_a, tail_b;
   logic [RunBits-1:0]     run_word;
   logic [RunBits-1:0]     head_run_a, head_run_b;
   logic [COORD_BITS-1:0]  a_row, a_start, a_end, b_row, b_start, b_end;
   logic                   full_a, full_b, out_free;
   logic                   drop_a, drop_b, overlap, pop_a, go;
   logic [COORD_BITS-1:0]  ov_start, ov_end;

   function automatic logic [AddrBits-1:0] tail_of(input logic [AddrBits-1:0] head,
                                                   input logic [CountBits-1:0] count);
      logic [SumBits-1:0] sum;
      sum = SumBits'(head) + SumBits'(count);
      if (sum >= SumBits'(QUEUE_DEPTH)) begin
         sum = sum - SumBits'(QUEUE_DEPTH);
      end
      return sum[AddrBits-1:0];
   endfunction

   function automatic logic [AddrBits-1:0] next_head(input logic [AddrBits-1:0] head);
      return (head == AddrBits'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
   endfunction

   assign tail_a   = tail_of(head_a_ff, cnt_a_ff);
   assign tail_b   = tail_of(head_b_ff, cnt_b_ff);
   assign full_a   = (cnt_a_ff == CountBits'(QUEUE_DEPTH));
   assign full_b   = (cnt_b_ff == CountBits'(QUEUE_DEPTH));
   assign run_word = {cmd_row, cmd_start, cmd_end};

   rlri_ram #(.WIDTH(RunBits), .DEPTH(QUEUE_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (tail_a),
      .wr_data (run_word),
      .rd_addr (head_a_ff),
      .rd_data (head_run_a)
   );

   rlri_ram #(.WIDTH(RunBits), .DEPTH(QUEUE_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (tail_b),
      .wr_data (run_word),
      .rd_addr (head_b_ff),
      .rd_data (head_run_b)
   );

   assign {a_row, a_start, a_end} = head_run_a;
   assign {b_row, b_start, b_end} = head_run_b;

   // Head comparison: a run wholly before the other is discarded, else they overlap.
   assign drop_a   = (a_row < b_row) || ((a_row == b_row) && (a_end <= b_start));
   assign drop_b   = !drop_a &&
                     ((b_row < a_row) || ((a_row == b_row) && (b_end <= a_start)));
   assign overlap  = !drop_a && !drop_b;
   assign pop_a    = drop_a || (overlap && (a_end < b_end));
   assign ov_start = (a_start > b_start) ? a_start : b_start;
   assign ov_end   = (a_end < b_end) ? a_end : b_end;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // A new overlap pushes the held result out, which needs the output register.
   assign go       = !(overlap && pend_valid_ff && !out_free);

   always_comb begin
      state_in      = state_ff;
      head_a_in     = head_a_ff;
      head_b_in     = head_b_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_row_in    = rsp_row_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      cmd_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_kind)
                  rlri_pkg::OPC_END: begin
                     if (out_free) begin
                        cmd_ready    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_row_in   = '0;
                        rsp_start_in = '0;
                        rsp_end_in   = '0;
                        rsp_last_in  = 1'b1;
                        rsp_done_in  = 1'b1;
                        rsp_ovf_in   = ovf_ff;
                        head_a_in    = '0;
                        head_b_in    = '0;
                        cnt_a_in     = '0;
                        cnt_b_in     = '0;
                        ovf_in       = 1'b0;
                     end
                  end
                  rlri_pkg::OPC_FIRST: begin
                     cmd_ready = 1'b1;
                     if (full_a) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + 1'b1;
                        if (cnt_b_ff != '0) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  rlri_pkg::OPC_SECOND: begin
                     cmd_ready = 1'b1;
                     if (full_b) begin
                        ovf_in = 1'b1;
                     end else begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + 1'b1;
                        if (cnt_a_ff != '0) begin
                           state_in = ST_READ;
                        end
                     end
                  end
                  default: begin
                     cmd_ready = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (go) begin
               if (pop_a) begin
                  cnt_a_in  = cnt_a_ff - 1'b1;
                  head_a_in = next_head(head_a_ff);
               end else begin
                  cnt_b_in  = cnt_b_ff - 1'b1;
                  head_b_in = next_head(head_b_ff);
               end
               if (overlap) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = pend_row_ff;
                     rsp_start_in = pend_start_ff;
                     rsp_end_in   = pend_end_ff;
                     rsp_last_in  = 1'b0;
                     rsp_done_in  = 1'b0;
                     rsp_ovf_in   = ovf_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = a_row;
                  pend_start_in = ov_start;
                  pend_end_in   = ov_end;
               end
               if ((cnt_a_in != '0) && (cnt_b_in != '0)) begin
                  state_in = ST_READ;
               end else if (pend_valid_in) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = pend_row_ff;
               rsp_start_in  = pend_start_ff;
               rsp_end_in    = pend_end_ff;
               rsp_last_in   = 1'b1;
               rsp_done_in   = 1'b0;
               rsp_ovf_in    = ovf_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_a_ff     <= '0;
         head_b_ff     <= '0;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_a_ff     <= head_a_in;
         head_b_ff     <= head_b_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_row_ff   <= pend_row_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_start  = rsp_start_ff;
   assign rsp_out_end    = rsp_end_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_frame_done = rsp_done_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

`default_nettype wire

[hw/rtl/rlri_checker.sv]
// Port-level checker for the region intersection core, with its bind.
`default_nettype none

module rlri_checker #(
   parameter int COORD_BITS = rlri_pkg::COORD_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic [1:0]            req_opcode,
   input wire logic [COORD_BITS-1:0] req_run_row,
   input wire logic [COORD_BITS-1:0] req_run_start,
   input wire logic [COORD_BITS-1:0] req_run_end,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_out_row,
   input wire logic [COORD_BITS-1:0] rsp_out_start,
   input wire logic [COORD_BITS-1:0] rsp_out_end,
   input wire logic                  rsp_is_last,
   input wire logic                  rsp_frame_done,
   input wire logic                  rsp_overflow
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row) &&
      $stable(rsp_out_start) && $stable(rsp_out_end) && $stable(rsp_is_last) &&
      $stable(rsp_frame_done) && $stable(rsp_overflow))
      else $error("result changed while stalled");

   // A done result is alone for its request and carries no run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_is_last && (rsp_out_row == '0) &&
      (rsp_out_start == '0) && (rsp_out_end == '0))
      else $error("malformed done result");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // Overflow only clears through a done result, which still reports it set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_overflow && !rsp_frame_done |=>
      !rsp_valid || rsp_overflow)
      else $error("overflow flag cleared without a done result");

   // A waiting request keeps its contents until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_opcode) &&
      $stable(req_run_row) && $stable(req_run_start) && $stable(req_run_end))
      else $error("request changed while waiting");

endmodule

bind run_length_region_intersection_core rlri_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the run-length region intersection core.
`default_nettype none

module testbench;

   localparam int COORD_BITS     = rlri_pkg::COORD_BITS_DEF;
   localparam int QUEUE_DEPTH    = rlri_pkg::QUEUE_DEPTH_DEF;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type row;
      coord_type first_col;
      coord_type end_col;
   } run_span_type;

   typedef struct packed {
      coord_type row;
      coord_type start_col;
      coord_type end_col;
      logic      is_last;
      logic      frame_done;
      logic      overflow;
   } intersect_result_type;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   rlri_pkg::opcode_type req_opcode    = rlri_pkg::OPC_NONE;
   coord_type            req_run_row   = '0;
   coord_type            req_run_start = '0;
   coord_type            req_run_end   = '0;
   logic                 rsp_ready     = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   coord_type            rsp_out_row;
   coord_type            rsp_out_start;
   coord_type            rsp_out_end;
   logic                 rsp_is_last;
   logic                 rsp_frame_done;
   logic                 rsp_overflow;

   // Predictor state: the pending runs of each region and the sticky flag.
   run_span_type         first_runs[$];
   run_span_type         second_runs[$];
   logic                 overflow_sticky;
   intersect_result_type expected_results[$];

   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int error_count       = 0;
   int requests_sent     = 0;
   int intersections_seen = 0;
   int frames_closed     = 0;
   int overflow_reports  = 0;
   int quiet_cycles      = 0;

   run_length_region_intersection_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_run_row    (req_run_row),
      .req_run_start  (req_run_start),
      .req_run_end    (req_run_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_start  (rsp_out_start),
      .rsp_out_end    (rsp_out_end),
      .rsp_is_last    (rsp_is_last),
      .rsp_frame_done (rsp_frame_done),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Queue the run and merge the region heads until one side runs dry; an end closes the frame.
   function automatic void predict_intersections(rlri_pkg::opcode_type op, coord_type row,
                                                 coord_type start_col, coord_type end_col);
      intersect_result_type produced[$];
      intersect_result_type res;
      run_span_type         incoming;
      run_span_type         a;
      run_span_type         b;
      if (op == rlri_pkg::OPC_END) begin
         res = '0;
         res.is_last = 1'b1;
         res.frame_done = 1'b1;
         res.overflow = overflow_sticky;
         expected_results.push_back(res);
         first_runs.delete();
         second_runs.delete();
         overflow_sticky = 1'b0;
         return;
      end
      if (op == rlri_pkg::OPC_NONE) return;
      incoming.row = row;
      incoming.first_col = start_col;
      incoming.end_col = end_col;
      if (op == rlri_pkg::OPC_FIRST) begin
         if (first_runs.size() >= QUEUE_DEPTH) begin
            overflow_sticky = 1'b1;
            return;
         end
         first_runs.push_back(incoming);
      end else begin
         if (second_runs.size() >= QUEUE_DEPTH) begin
            overflow_sticky = 1'b1;
            return;
         end
         second_runs.push_back(incoming);
      end
      while (first_runs.size() > 0 && second_runs.size() > 0) begin
         a = first_runs[0];
         b = second_runs[0];
         if (a.row < b.row || (a.row == b.row && a.end_col <= b.first_col)) begin
            void'(first_runs.pop_front());
         end else if (b.row < a.row || (a.row == b.row && b.end_col <= a.first_col)) begin
            void'(second_runs.pop_front());
         end else begin
            res = '0;
            res.row = a.row;
            res.start_col = (a.first_col > b.first_col) ? a.first_col : b.first_col;
            res.end_col = (a.end_col < b.end_col) ? a.end_col : b.end_col;
            res.overflow = overflow_sticky;
            produced.push_back(res);
            if (a.end_col < b.end_col) void'(first_runs.pop_front());
            else void'(second_runs.pop_front());
         end
      end
      if (produced.size() > 0) produced[produced.size()-1].is_last = 1'b1;
      foreach (produced[i]) expected_results.push_back(produced[i]);
   endfunction

   task automatic send_request(input rlri_pkg::opcode_type op, input coord_type row,
                               input coord_type start_col, input coord_type end_col);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_run_row   <= row;
      req_run_start <= start_col;
      req_run_end   <= end_col;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_intersections(op, row, start_col, end_col);
      requests_sent++;
   endtask

   task automatic send_noise();
      send_request(rlri_pkg::opcode_type'($urandom_range(3)), coord_type'($urandom()),
                   coord_type'($urandom()), coord_type'($urandom()));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hand-picked overlaps, ties, drops, the extremes of the coordinates,
   // a degenerate run and the unused opcode.
   task automatic test_directed_overlaps();
      send_request(rlri_pkg::OPC_FIRST,  16'd0, 16'd0,  16'd10);
      send_request(rlri_pkg::OPC_SECOND, 16'd0, 16'd5,  16'd15);
      send_request(rlri_pkg::OPC_FIRST,  16'd0, 16'd12, 16'd20);
      send_request(rlri_pkg::OPC_SECOND, 16'd0, 16'd20, 16'd30);
      send_request(rlri_pkg::OPC_FIRST,  16'd1, 16'd0,  16'd5);
      send_request(rlri_pkg::OPC_SECOND, 16'd1, 16'd0,  16'd5);
      send_request(rlri_pkg::OPC_NONE,   16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(rlri_pkg::OPC_SECOND, 16'hFFFF, 16'd100, 16'd50);
      send_request(rlri_pkg::OPC_FIRST,  16'hFFFF, 16'd0, 16'hFFFF);
      send_request(rlri_pkg::OPC_END,    16'd0, 16'd0, 16'd0);
      wait_for_results();
   endtask

   // Fill the second queue, overrun it, then release every queued run at once.
   task automatic test_queue_overflow();
      for (int k = 0; k < QUEUE_DEPTH; k++)
         send_request(rlri_pkg::OPC_SECOND, 16'd7, coord_type'(4 * k),
                      coord_type'(4 * k + 2));
      send_request(rlri_pkg::OPC_SECOND, 16'd7, 16'd100, 16'd102);
      send_request(rlri_pkg::OPC_FIRST,  16'd7, 16'd0, 16'hFFFF);
      send_request(rlri_pkg::OPC_END,    16'd0, 16'd0, 16'd0);
      wait_for_results();
   endtask

   task automatic plan_region(ref run_span_type plan[$], input coord_type base_row,
                              input coord_type base_col, input int count);
      run_span_type span;
      int           cursor;
      span.row = base_row;
      cursor = base_col + $urandom_range(50);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            span.row = span.row + 1'b1;
            cursor = base_col + $urandom_range(50);
         end
         span.first_col = coord_type'(cursor);
         cursor = cursor + $urandom_range(1, 120);
         span.end_col = coord_type'(cursor);
         cursor = cursor + $urandom_range(60);
         plan.push_back(span);
      end
   endtask

   // Well-formed region pairs with random interleaving, sprinkled with noise.
   task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                     input int item_target);
      run_span_type first_plan[$];
      run_span_type second_plan[$];
      run_span_type span;
      coord_type    base_row;
      coord_type    base_col;
      int           start_count;
      bit           take_first;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      start_count = requests_sent;
      while (requests_sent - start_count < item_target) begin
         base_row = coord_type'($urandom_range(16'hFFF0));
         base_col = coord_type'($urandom_range(64000));
         plan_region(first_plan, base_row, base_col, $urandom_range(1, 8));
         plan_region(second_plan, base_row, base_col, $urandom_range(1, 8));
         while (first_plan.size() > 0 || second_plan.size() > 0) begin
            if ($urandom_range(99) < 10) send_noise();
            take_first = (second_plan.size() == 0) ||
                         (first_plan.size() > 0 && $urandom_range(1) == 1);
            if (take_first) begin
               span = first_plan.pop_front();
               send_request(rlri_pkg::OPC_FIRST, span.row, span.first_col, span.end_col);
            end else begin
               span = second_plan.pop_front();
               send_request(rlri_pkg::OPC_SECOND, span.row, span.first_col, span.end_col);
            end
         end
         send_request(rlri_pkg::OPC_END, coord_type'($urandom()), coord_type'($urandom()),
                      coord_type'($urandom()));
      end
      wait_for_results();
   endtask

   function automatic void check_field(string field, logic [31:0] expected,
                                       logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      intersect_result_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing pending: row %0d start %0d end %0d done %0b",
                      rsp_out_row, rsp_out_start, rsp_out_end, rsp_frame_done);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("out_row", 32'(want.row), 32'(rsp_out_row));
               check_field("out_start", 32'(want.start_col), 32'(rsp_out_start));
               check_field("out_end", 32'(want.end_col), 32'(rsp_out_end));
               check_field("is_last", 32'(want.is_last), 32'(rsp_is_last));
               check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
               if (want.frame_done) frames_closed++;
               else intersections_seen++;
               if (want.overflow) overflow_reports++;
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results still pending",
                     quiet_cycles, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      overflow_sticky = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_overlaps();
      test_queue_overflow();
      test_random_frames(0, 0, 18);
      test_random_frames(85, 0, 16);
      test_random_frames(0, 85, 16);
      test_random_frames(7, 7, 16);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         error_count++;
      end
      $display("Sent %0d requests; checked %0d intersection runs and %0d frame ends,",
               requests_sent, intersections_seen, frames_closed);
      $display("%0d of them flagging a dropped run, under four idle and stall mixes.",
               overflow_reports);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
